[rtl/swept_box_ray_hit_test_macros.svh]
// Assertion macros used by the swept box hit test top level.
`ifndef SWEPT_BOX_RAY_HIT_TEST_MACROS_SVH
`define SWEPT_BOX_RAY_HIT_TEST_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, switched off while reset is asserted.
`define SBRH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("sbrh assertion failed");
// Checked property, also during reset.
`define SBRH_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("sbrh assertion failed");
`else
`define SBRH_ASSERT(lbl, clk, rstn, prop)
`define SBRH_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/sbrh_pkg.sv]
// Types and constants of the swept box hit test.
package sbrh_pkg;

  localparam int COORD_W  = 24;
  localparam int SIZE_W   = 12;
  localparam int ENTRY_W  = 17;
  localparam int NORMAL_W = 3;

  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int TIME_FRAC_BITS_DEF  = 16;

  typedef enum logic [NORMAL_W-1:0] {
    NORM_NONE  = 3'd0,
    NORM_POS_X = 3'd1,
    NORM_NEG_X = 3'd2,
    NORM_POS_Y = 3'd3,
    NORM_NEG_Y = 3'd4
  } sbrh_normal_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic [SIZE_W-1:0]         target_width;
    logic [SIZE_W-1:0]         target_height;
    logic [SIZE_W-1:0]         mover_width;
    logic [SIZE_W-1:0]         mover_height;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } sbrh_in_t;

  typedef struct packed {
    logic                      hit;
    logic [ENTRY_W-1:0]        entry_time;
    logic signed [COORD_W-1:0] contact_x;
    logic signed [COORD_W-1:0] contact_y;
    logic [NORMAL_W-1:0]       normal_code;
  } sbrh_out_t;

endpackage

[rtl/swept_box_ray_hit_test.sv]
// Top level of the swept box hit test: slab set-up, four dividers, resolve and contact.
//
//  channel | signals                        | direction
//  in      | in_valid_i, in_ready_o, in_word_i   | box pair and motion segment in
//  out     | out_valid_o, out_ready_i, out_word_o | hit, entry time, contact, normal out
//
// One word is taken per cycle while the output register is empty or being taken; the
// pipeline depth is set by the restoring dividers that yield one quotient bit per stage.
// Reset clears only the valid bits of the pipeline.
// The whole pipeline advances when the output register is empty or being taken,
// so a stall freezes every stage and no word is dropped or repeated.
`include "swept_box_ray_hit_test_macros.svh"
module swept_box_ray_hit_test #(
  parameter int COORD_FRAC_BITS = sbrh_pkg::COORD_FRAC_BITS_DEF,
  parameter int TIME_FRAC_BITS  = sbrh_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sbrh_pkg::sbrh_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbrh_pkg::sbrh_out_t out_word_o
);
  import sbrh_pkg::*;

  localparam int CW    = COORD_W;
  localparam int DW    = COORD_W + 1;
  localparam int NUM_W = ((CW + 1 > SIZE_W + COORD_FRAC_BITS) ?
                          CW + 1 : SIZE_W + COORD_FRAC_BITS) + 2;
  localparam int QW    = TIME_FRAC_BITS + 2;
  localparam int TW    = TIME_FRAC_BITS + 3;
  localparam int TNW   = TIME_FRAC_BITS + 1;
  localparam int PW    = TNW + 1 + DW;
  localparam int TNX_W = (TNW > ENTRY_W) ? TNW : ENTRY_W;
  localparam logic signed [TW-1:0] T_ONE = TW'(1 << TIME_FRAC_BITS);

  typedef struct packed {
    logic signed [NUM_W-1:0] nnx;
    logic signed [NUM_W-1:0] nfx;
    logic signed [NUM_W-1:0] nny;
    logic signed [NUM_W-1:0] nfy;
    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic signed [CW-1:0]    sx;
    logic signed [CW-1:0]    sy;
  } front_t;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
  } side_t;

  typedef struct packed {
    logic                 hit;
    logic [TNW-1:0]       tn;
    logic [NORMAL_W-1:0]  code;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
  } res_t;

  typedef struct packed {
    logic                 hit;
    logic [TNW-1:0]       tn;
    logic [NORMAL_W-1:0]  code;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
  } mul_t;

  logic     en;
  logic     f_vld_q;
  front_t   f_q, f_d;
  logic     vld_q  [QW+1];
  side_t    side_q [QW+1];
  logic     res_vld_q;
  res_t     res_q, res_d;
  logic     mul_vld_q;
  mul_t     mul_q, mul_d;
  logic     out_vld_q;
  sbrh_out_t out_q, out_d;

  logic signed [TW-1:0] t_nx, t_fx, t_ny, t_fy;
  logic u_nx, u_fx, u_ny, u_fy;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // Slab numerators: grown box edges relative to the start point.
  always_comb begin
    logic signed [NUM_W-1:0] tx, ty, sx, sy;
    logic [NUM_W-1:0] mw, mh, tw, th;
    tx = NUM_W'(in_word_i.target_x);
    ty = NUM_W'(in_word_i.target_y);
    sx = NUM_W'(in_word_i.start_x);
    sy = NUM_W'(in_word_i.start_y);
    mw = NUM_W'(in_word_i.mover_width) << COORD_FRAC_BITS;
    mh = NUM_W'(in_word_i.mover_height) << COORD_FRAC_BITS;
    tw = NUM_W'(in_word_i.target_width) << COORD_FRAC_BITS;
    th = NUM_W'(in_word_i.target_height) << COORD_FRAC_BITS;
    f_d.nnx = tx - signed'(mw) - sx;
    f_d.nfx = tx + signed'(tw) - sx;
    f_d.nny = ty - signed'(mh) - sy;
    f_d.nfy = ty + signed'(th) - sy;
    f_d.dx  = DW'(in_word_i.end_x) - DW'(in_word_i.start_x);
    f_d.dy  = DW'(in_word_i.end_y) - DW'(in_word_i.start_y);
    f_d.sx  = in_word_i.start_x;
    f_d.sy  = in_word_i.start_y;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q <= f_d;
    end
  end

  sbrh_slab #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS),
              .NUM_W(NUM_W)) u_slab_nx (
    .clk_i(clk_i), .en_i(en), .num_i(f_q.nnx), .d_i(f_q.dx), .time_o(t_nx), .undef_o(u_nx));
  sbrh_slab #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS),
              .NUM_W(NUM_W)) u_slab_fx (
    .clk_i(clk_i), .en_i(en), .num_i(f_q.nfx), .d_i(f_q.dx), .time_o(t_fx), .undef_o(u_fx));
  sbrh_slab #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS),
              .NUM_W(NUM_W)) u_slab_ny (
    .clk_i(clk_i), .en_i(en), .num_i(f_q.nny), .d_i(f_q.dy), .time_o(t_ny), .undef_o(u_ny));
  sbrh_slab #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .TIME_FRAC_BITS(TIME_FRAC_BITS),
              .NUM_W(NUM_W)) u_slab_fy (
    .clk_i(clk_i), .en_i(en), .num_i(f_q.nfy), .d_i(f_q.dy), .time_o(t_fy), .undef_o(u_fy));

  // Side data and valid bits run alongside the divider stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{dx: f_q.dx, dy: f_q.dy, sx: f_q.sx, sy: f_q.sy};
      for (int k = 1; k <= QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q   <= 1'b0;
      for (int k = 0; k <= QW; k++) begin
        vld_q[k] <= 1'b0;
      end
      res_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q   <= in_valid_i;
      vld_q[0]  <= f_vld_q;
      for (int k = 1; k <= QW; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      res_vld_q <= vld_q[QW];
      mul_vld_q <= res_vld_q;
      out_vld_q <= mul_vld_q;
    end
  end

  // Order the slab times, test overlap and pick the face.
  always_comb begin
    logic signed [TW-1:0] nx, fx, ny, fy, tn, tf;
    side_t s;
    logic miss;
    s  = side_q[QW];
    nx = (t_nx > t_fx) ? t_fx : t_nx;
    fx = (t_nx > t_fx) ? t_nx : t_fx;
    ny = (t_ny > t_fy) ? t_fy : t_ny;
    fy = (t_ny > t_fy) ? t_ny : t_fy;
    tn = (nx > ny) ? nx : ny;
    tf = (fx < fy) ? fx : fy;
    miss = u_nx || u_fx || u_ny || u_fy || (nx > fy) || (ny > fx) ||
           (tf < 0) || (tn > T_ONE) || (tn < 0);
    res_d.hit = !miss;
    res_d.tn  = miss ? '0 : TNW'(tn);
    if (miss || nx == ny) begin
      res_d.code = NORM_NONE;
    end else if (nx > ny) begin
      res_d.code = s.dx[DW-1] ? NORM_POS_X : NORM_NEG_X;
    end else begin
      res_d.code = s.dy[DW-1] ? NORM_POS_Y : NORM_NEG_Y;
    end
    res_d.dx = s.dx;
    res_d.dy = s.dy;
    res_d.sx = s.sx;
    res_d.sy = s.sy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      mul_q <= mul_d;
      out_q <= out_d;
    end
  end

  always_comb begin
    mul_d.hit  = res_q.hit;
    mul_d.tn   = res_q.tn;
    mul_d.code = res_q.code;
    mul_d.px   = PW'(signed'({1'b0, res_q.tn})) * PW'(res_q.dx);
    mul_d.py   = PW'(signed'({1'b0, res_q.tn})) * PW'(res_q.dy);
    mul_d.sx   = res_q.sx;
    mul_d.sy   = res_q.sy;
  end

  // The arithmetic shift floors the product, as the contact point needs.
  always_comb begin
    logic signed [PW-1:0] shx, shy;
    logic [TNX_W-1:0] tn_ext;
    shx    = mul_q.px >>> TIME_FRAC_BITS;
    shy    = mul_q.py >>> TIME_FRAC_BITS;
    tn_ext = TNX_W'(mul_q.tn);
    out_d.hit         = mul_q.hit;
    out_d.entry_time  = tn_ext[ENTRY_W-1:0];
    out_d.contact_x   = mul_q.hit ? mul_q.sx + shx[CW-1:0] : '0;
    out_d.contact_y   = mul_q.hit ? mul_q.sy + shy[CW-1:0] : '0;
    out_d.normal_code = mul_q.code;
  end

  `SBRH_ASSERT(a_miss_zero, clk_i, rst_ni,
    (out_vld_q && !out_q.hit) |-> (out_q.entry_time == '0 && out_q.normal_code == NORM_NONE && out_q.contact_x == '0 && out_q.contact_y == '0))
  `SBRH_ASSERT(a_hit_in_step, clk_i, rst_ni,
    (res_vld_q && res_q.hit) |-> (res_q.tn <= TNW'(1 << TIME_FRAC_BITS)))
  `SBRH_ASSERT(a_accept_enters, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> f_vld_q)
  `SBRH_ASSERT(a_stall_freezes, clk_i, rst_ni,
    (!en) |=> ($stable(res_vld_q) && $stable(mul_vld_q) && $stable(f_vld_q)))

endmodule

[rtl/sbrh_slab.sv]
// One slab crossing time: sign handling, pipelined restoring divider and clamp.
module sbrh_slab #(
  parameter int COORD_FRAC_BITS = sbrh_pkg::COORD_FRAC_BITS_DEF,
  parameter int TIME_FRAC_BITS  = sbrh_pkg::TIME_FRAC_BITS_DEF,
  parameter int NUM_W = ((sbrh_pkg::COORD_W + 1 > sbrh_pkg::SIZE_W + COORD_FRAC_BITS) ?
                         sbrh_pkg::COORD_W + 1 : sbrh_pkg::SIZE_W + COORD_FRAC_BITS) + 2
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [NUM_W-1:0]             num_i,
  input  logic signed [sbrh_pkg::COORD_W:0]   d_i,
  output logic signed [TIME_FRAC_BITS+2:0]    time_o,
  output logic                                undef_o
);
  import sbrh_pkg::*;

  localparam int DW = COORD_W + 1;
  localparam int RW = COORD_W + 3;
  localparam int QW = TIME_FRAC_BITS + 2;
  localparam int TW = TIME_FRAC_BITS + 3;
  localparam logic [QW-1:0] Q_SAT = QW'((1 << TIME_FRAC_BITS) + 1);
  localparam logic signed [TW-1:0] T_SAT = TW'((1 << TIME_FRAC_BITS) + 1);
  localparam logic signed [TW-1:0] T_NEG = '1;

  logic [RW-1:0]          r_q   [QW+1];
  logic [RW-1:0]          dv_q  [QW+1];
  logic [QW-1:0]          q_q   [QW+1];
  logic                   pre_q [QW+1];
  logic signed [TW-1:0]   pt_q  [QW+1];
  logic                   un_q  [QW+1];

  logic                   d_neg;
  logic [DW-1:0]          dmag;
  logic signed [NUM_W-1:0] np;
  logic [RW-1:0]          dv4;
  logic                   big;
  logic [RW-1:0]          r_d;
  logic                   pre_d;
  logic signed [TW-1:0]   pt_d;
  logic                   un_d;

  // Times below zero or above one are clamped to minus one step or to one plus a step,
  // which leaves the outcome unchanged, so the quotient needs only two integer bits.
  always_comb begin
    d_neg = d_i[DW-1];
    dmag  = d_neg ? DW'(-d_i) : DW'(d_i);
    np    = d_neg ? -num_i : num_i;
    dv4   = {dmag, 2'b00};
    big   = np >= signed'(NUM_W'(dv4));
    r_d   = RW'(np);
    pre_d = 1'b1;
    pt_d  = '0;
    un_d  = 1'b0;
    priority if (d_i == '0) begin
      un_d = (num_i == '0);
      pt_d = (num_i > 0) ? T_SAT : T_NEG;
    end else if (np <= 0) begin
      pt_d = (np == '0) ? '0 : T_NEG;
    end else if (big) begin
      pt_d = T_SAT;
    end else begin
      pre_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= r_d;
      dv_q[0]  <= dv4;
      q_q[0]   <= '0;
      pre_q[0] <= pre_d;
      pt_q[0]  <= pt_d;
      un_q[0]  <= un_d;
    end
  end

  // One quotient bit per stage against four times the divisor.
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [RW:0]   r2;
    logic          ge;
    logic [RW:0]   diff;
    always_comb begin
      r2   = {r_q[k-1], 1'b0};
      ge   = r2 >= {1'b0, dv_q[k-1]};
      diff = r2 - {1'b0, dv_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? diff[RW-1:0] : r2[RW-1:0];
        dv_q[k]  <= dv_q[k-1];
        q_q[k]   <= {q_q[k-1][QW-2:0], ge};
        pre_q[k] <= pre_q[k-1];
        pt_q[k]  <= pt_q[k-1];
        un_q[k]  <= un_q[k-1];
      end
    end
  end

  always_comb begin
    if (pre_q[QW]) begin
      time_o = pt_q[QW];
    end else if (q_q[QW] > Q_SAT) begin
      time_o = T_SAT;
    end else begin
      time_o = signed'(TW'(q_q[QW]));
    end
    undef_o = un_q[QW];
  end

endmodule
